@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the positional list table.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Check a delayed consequence of a trigger.
`define ASSERT_LAT2(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> ##2 (cond)) \
        else $error(msg);

`endif

@@ design/plt_pkg.sv @@
// ----------------------------------------------------------------------------
// plt_pkg
// Request, response and control word types and operation codes of the positional list.
// ----------------------------------------------------------------------------
package plt_pkg;

    localparam logic [1:0] FUNC_INSERT   = 2'd0;
    localparam logic [1:0] FUNC_REMOVE   = 2'd1;
    localparam logic [1:0] FUNC_RETRIEVE = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [4:0]  position;
        logic [31:0] item_in;
    } plt_req_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] item_out;
        logic [4:0]  length;
    } plt_rsp_t;

    typedef struct packed {
        logic ok;
        logic ins;
        logic rem;
        logic rd;
    } plt_ctrl_t;

endpackage

@@ design/positional_list_table.sv @@
// ----------------------------------------------------------------------------
// positional_list_table
// Ordered list addressed by 1-based position: insert, remove and retrieve.
// ----------------------------------------------------------------------------
//  channel   handshake            word
//  request   start && !busy       req  (func, position, item_in)
//  response  done, one cycle      rsp  (ok, item_out, length)
//
// One request is taken every cycle; busy stays low.
// The request waits in the request register after acceptance; the decode and
// the cell read port then feed the response register.
// Reset clears the length and the strobes; cell contents are unknown until
// written. The receiver cannot stall, so the response is never held.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module positional_list_table
    import plt_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int ITEM_WIDTH = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  plt_req_t req,
    output logic     done,
    output plt_rsp_t rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                  req_vld_reg;
    plt_req_t              req_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  done_reg;
    plt_rsp_t              rsp_reg;
    plt_rsp_t              rsp_next;
    plt_ctrl_t             ctrl;
    logic [IDX_W-1:0]      idx;
    logic [ITEM_WIDTH-1:0] rd_data;
    logic [ITEM_WIDTH-1:0] word;

    assign busy = 1'b0;
    assign word = ITEM_WIDTH'(req_reg.item_in);

    plt_decode #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_decode (
        .vld        (req_vld_reg),
        .req        (req_reg),
        .count      (count_reg),
        .ctrl       (ctrl),
        .idx        (idx),
        .count_next (count_next)
    );

    plt_cell_array #(
        .CAPACITY   (CAPACITY),
        .ITEM_WIDTH (ITEM_WIDTH),
        .IDX_W      (IDX_W)
    ) u_cells (
        .clk     (clk),
        .ctrl    (ctrl),
        .idx     (idx),
        .word    (word),
        .rd_data (rd_data)
    );

    always_comb
    begin
        rsp_next.ok       = ctrl.ok;
        rsp_next.item_out = ctrl.rd ? 32'(rd_data) : 32'd0;
        rsp_next.length   = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            req_vld_reg <= start && !busy;
            count_reg   <= count_next;
            done_reg    <= req_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req;
        end
        if (req_vld_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    `ASSERT_LAT2(a_done_latency, start && !busy, done, "response missing two cycles after request")
    `ASSERT_NOW(a_len_bound, done, 32'(count_reg) <= CAPACITY, "list length above capacity")
    `ASSERT_NOW(a_len_only_on_done, !$stable(count_reg), done, "length changed without a response")
    `ASSERT_NOW(a_refused_zero, done && !rsp.ok, rsp.item_out == 32'd0, "refused request returned data")

endmodule

@@ design/plt_decode.sv @@
// ----------------------------------------------------------------------------
// plt_decode
// Range checks on a registered request and the list length that follows it.
// ----------------------------------------------------------------------------
module plt_decode
    import plt_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic             vld,
    input  plt_req_t         req,
    input  logic [CNT_W-1:0] count,
    output plt_ctrl_t        ctrl,
    output logic [IDX_W-1:0] idx,
    output logic [CNT_W-1:0] count_next
);

    localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

    logic [CMP_W-1:0] pos_e;
    logic [CMP_W-1:0] cnt_e;
    logic             pos_nz;
    logic             in_list;
    logic             in_gap;
    logic             room;

    assign pos_e   = CMP_W'(req.position);
    assign cnt_e   = CMP_W'(count);
    assign pos_nz  = (req.position != 5'd0);
    assign in_list = pos_nz && (pos_e <= cnt_e);
    assign in_gap  = pos_nz && (pos_e <= cnt_e + CMP_W'(1));
    assign room    = (cnt_e < CMP_W'(CAPACITY));
    assign idx     = IDX_W'(req.position - 5'd1);

    always_comb
    begin
        ctrl       = '0;
        count_next = count;
        if (vld)
        begin
            case (req.func)
                FUNC_INSERT:
                begin
                    ctrl.ins = in_gap && room;
                end
                FUNC_REMOVE:
                begin
                    ctrl.rem = in_list;
                end
                FUNC_RETRIEVE:
                begin
                    ctrl.rd = in_list;
                end
                default:
                begin
                    ctrl = '0;
                end
            endcase
            ctrl.ok = ctrl.ins || ctrl.rem || ctrl.rd;
            if (ctrl.ins)
            begin
                count_next = count + CNT_W'(1);
            end
            else if (ctrl.rem)
            begin
                count_next = count - CNT_W'(1);
            end
        end
    end

endmodule

@@ design/plt_cell_array.sv @@
// ----------------------------------------------------------------------------
// plt_cell_array
// Row of list cells; each cell loads, shifts back, shifts forward or holds.
// ----------------------------------------------------------------------------
module plt_cell_array
    import plt_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int ITEM_WIDTH = 32,
    parameter int IDX_W      = $clog2(CAPACITY)
) (
    input  logic                  clk,
    input  plt_ctrl_t             ctrl,
    input  logic [IDX_W-1:0]      idx,
    input  logic [ITEM_WIDTH-1:0] word,
    output logic [ITEM_WIDTH-1:0] rd_data
);

    logic [ITEM_WIDTH-1:0] cells [CAPACITY];

    assign rd_data = cells[idx];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ITEM_WIDTH-1:0] prev_w;
        logic [ITEM_WIDTH-1:0] succ_w;

        if (i == 0)
        begin : g_first
            assign prev_w = word;
        end
        else
        begin : g_mid_prev
            assign prev_w = cells[i-1];
        end

        // the last cell holds on a remove
        if (i == CAPACITY - 1)
        begin : g_last
            assign succ_w = cells[i];
        end
        else
        begin : g_mid_succ
            assign succ_w = cells[i+1];
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.ins)
            begin
                if (IDX_W'(i) == idx)
                begin
                    cells[i] <= word;
                end
                else if (IDX_W'(i) > idx)
                begin
                    cells[i] <= prev_w;
                end
            end
            else if (ctrl.rem && (IDX_W'(i) >= idx))
            begin
                cells[i] <= succ_w;
            end
        end
    end

endmodule

@@ test/tb_positional_list_table.sv @@
// ----------------------------------------------------------------------------
// tb_positional_list_table
// Self-checking bench for the positional list: drives insert, remove and
// retrieve requests through the start/busy port, predicts every response from
// a shadow copy of the list, and compares each done word field by field.
// ----------------------------------------------------------------------------

// Shadow copy of the list and the queue of responses still to come.
class list_tracker;
    localparam int SLOTS = 16;

    logic [31:0]        cells [SLOTS];
    int                 fill;
    plt_pkg::plt_rsp_t  pending [$];
    int unsigned        failures;
    int unsigned        taken;
    int unsigned        done_ok;
    int unsigned        refused;
    int unsigned        full_hits;
    int                 peak;

    function new();
        fill      = 0;
        failures  = 0;
        taken     = 0;
        done_ok   = 0;
        refused   = 0;
        full_hits = 0;
        peak      = 0;
        foreach (cells[i]) cells[i] = '0;
    endfunction

    // Apply one accepted request to the shadow list and queue its response.
    function void note_request(plt_pkg::plt_req_t w);
        plt_pkg::plt_rsp_t r;
        int                p;
        r = '0;
        p = int'(w.position);
        taken++;
        case (w.func)
            plt_pkg::FUNC_INSERT:
            begin
                if (fill == SLOTS)
                    full_hits++;
                if (p >= 1 && p <= fill + 1 && fill < SLOTS)
                begin
                    for (int i = fill; i >= p; i--)
                        cells[i] = cells[i - 1];
                    cells[p - 1] = w.item_in;
                    fill++;
                    r.ok = 1'b1;
                end
            end
            plt_pkg::FUNC_REMOVE:
            begin
                if (p >= 1 && p <= fill)
                begin
                    for (int i = p; i < fill; i++)
                        cells[i - 1] = cells[i];
                    fill--;
                    r.ok = 1'b1;
                end
            end
            plt_pkg::FUNC_RETRIEVE:
            begin
                if (p >= 1 && p <= fill)
                begin
                    r.item_out = cells[p - 1];
                    r.ok       = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.length = fill[4:0];
        if (r.ok)
            done_ok++;
        else
            refused++;
        if (fill > peak)
            peak = fill;
        pending.push_back(r);
    endfunction

    function void check_response(plt_pkg::plt_rsp_t got);
        plt_pkg::plt_rsp_t want;
        if (pending.size() == 0)
        begin
            $error("response word with nothing outstanding: %h", got);
            failures++;
            return;
        end
        want = pending.pop_front();
        if (got.ok !== want.ok)
        begin
            $error("ok: expected %0b, got %0b", want.ok, got.ok);
            failures++;
        end
        if (got.item_out !== want.item_out)
        begin
            $error("item_out: expected %h, got %h", want.item_out, got.item_out);
            failures++;
        end
        if (got.length !== want.length)
        begin
            $error("length: expected %0d, got %0d", want.length, got.length);
            failures++;
        end
    endfunction
endclass

module tb_positional_list_table
    import plt_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         PHASE_WORDS = 407;
    localparam int         CYCLE_LIMIT = 200000;

    typedef enum int {GROW, SHRINK, CHURN} mix_t;

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    plt_req_t req   = '0;
    logic     busy;
    logic     done;
    plt_rsp_t rsp;

    list_tracker tracker = new();
    int          cycles  = 0;

    positional_list_table u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("positional_list_table: mismatch");
            $finish;
        end
    end

    // Responses accepted at this edge belong to older requests, so check first.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                tracker.check_response(rsp);
            if (start && !busy)
                tracker.note_request(req);
        end
    end

    task automatic send_word(input plt_req_t w);
        start <= 1'b1;
        req   <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Hold start low for a random stretch; scramble the request bus meanwhile.
    task automatic idle_gap(input int pct);
        plt_req_t junk;
        while ($urandom_range(99) < pct)
        begin
            junk.func     = 2'($urandom);
            junk.position = 5'($urandom);
            junk.item_in  = $urandom;
            start <= 1'b0;
            req   <= junk;
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic plt_req_t random_word(input mix_t mix);
        plt_req_t w;
        int       r;
        int       top;
        r = $urandom_range(99);
        case (mix)
            GROW:
                w.func = (r < 75) ? FUNC_INSERT : (r < 85) ? FUNC_RETRIEVE :
                         (r < 95) ? FUNC_REMOVE : FUNC_UNUSED;
            SHRINK:
                w.func = (r < 20) ? FUNC_INSERT : (r < 80) ? FUNC_REMOVE :
                         (r < 95) ? FUNC_RETRIEVE : FUNC_UNUSED;
            default:
                w.func = (r < 35) ? FUNC_INSERT : (r < 65) ? FUNC_REMOVE :
                         (r < 95) ? FUNC_RETRIEVE : FUNC_UNUSED;
        endcase
        top = (w.func == FUNC_INSERT) ? tracker.fill + 1 : tracker.fill;
        r   = $urandom_range(99);
        if (r < 80)
            w.position = (top == 0) ? 5'd1 : 5'($urandom_range(top, 1));
        else if (r < 90)
            w.position = $urandom_range(1) ? 5'd0 : 5'(top + 1);
        else
            w.position = 5'($urandom_range(31));
        r = $urandom_range(19);
        if (r == 0)
            w.item_in = '0;
        else if (r == 1)
            w.item_in = '1;
        else
            w.item_in = $urandom;
        return w;
    endfunction

    plt_req_t directed [$];
    int       idle_pct [4] = '{0, 77, 0, 32};
    mix_t     mix;

    initial
    begin
        // Empty list: unused code, position zero, past the end.
        directed.push_back('{FUNC_UNUSED,   5'd31, 32'hFFFF_FFFF});
        directed.push_back('{FUNC_RETRIEVE, 5'd0,  32'h0});
        directed.push_back('{FUNC_REMOVE,   5'd1,  32'h0});
        directed.push_back('{FUNC_INSERT,   5'd2,  32'h1234_5678});
        directed.push_back('{FUNC_INSERT,   5'd0,  32'h1234_5678});
        // Build a short list at the front, the back and the middle.
        directed.push_back('{FUNC_INSERT,   5'd1,  32'h0000_0000});
        directed.push_back('{FUNC_INSERT,   5'd2,  32'hFFFF_FFFF});
        directed.push_back('{FUNC_INSERT,   5'd1,  32'hA5A5_A5A5});
        directed.push_back('{FUNC_INSERT,   5'd2,  32'h5A5A_5A5A});
        directed.push_back('{FUNC_RETRIEVE, 5'd1,  32'hFFFF_FFFF});
        directed.push_back('{FUNC_RETRIEVE, 5'd2,  32'h0});
        directed.push_back('{FUNC_RETRIEVE, 5'd3,  32'h0});
        directed.push_back('{FUNC_RETRIEVE, 5'd4,  32'h0});
        directed.push_back('{FUNC_RETRIEVE, 5'd5,  32'h0});
        directed.push_back('{FUNC_INSERT,   5'd31, 32'hDEAD_BEEF});
        directed.push_back('{FUNC_REMOVE,   5'd0,  32'h0});
        directed.push_back('{FUNC_REMOVE,   5'd5,  32'h0});
        directed.push_back('{FUNC_REMOVE,   5'd2,  32'h0});
        directed.push_back('{FUNC_RETRIEVE, 5'd2,  32'h0});
        directed.push_back('{FUNC_REMOVE,   5'd3,  32'h0});
        directed.push_back('{FUNC_REMOVE,   5'd1,  32'h0});
        directed.push_back('{FUNC_RETRIEVE, 5'd1,  32'h0});
        directed.push_back('{FUNC_UNUSED,   5'd1,  32'h0});
        directed.push_back('{FUNC_RETRIEVE, 5'd31, 32'h0});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_word(directed[i]);
        wait_drained();

        mix = GROW;
        foreach (idle_pct[ph])
        begin
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // Swing the list between full and empty in blocks of words.
                if (n % 40 == 0)
                    mix = mix_t'($urandom_range(2));
                idle_gap(idle_pct[ph]);
                send_word(random_word(mix));
            end
            wait_drained();
        end

        repeat (8) @(posedge clk);
        $display("ran %0d requests: %0d done, %0d refused, %0d inserts on a full list",
                 tracker.taken, tracker.done_ok, tracker.refused, tracker.full_hits);
        $display("longest list held: %0d words", tracker.peak);
        if (tracker.failures == 0 && tracker.pending.size() == 0)
        begin
            $display("positional_list_table: match");
        end
        else
        begin
            if (tracker.pending.size() != 0)
                $error("%0d responses never arrived", tracker.pending.size());
            $display("positional_list_table: mismatch");
        end
        $finish;
    end

endmodule
